// ----- sv/ordered_list_insert_delete_assert.svh -----
// assertion macros used by the ordered list back end
`ifndef ORDERED_LIST_INSERT_DELETE_ASSERT_SVH
`define ORDERED_LIST_INSERT_DELETE_ASSERT_SVH

// condition that holds at every clock edge out of reset
`define OLID_ASSERT_ALWAYS(lbl, clk, rst_n, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error(msg);

// condition that holds in the same cycle as its trigger
`define OLID_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

// ----- sv/olid_pkg.sv -----
// shared types and codes of the ordered list block
package olid_pkg;

    // action codes of an input beat
    localparam logic [1:0] ACT_INSERT   = 2'd0;
    localparam logic [1:0] ACT_DELETE   = 2'd1;
    localparam logic [1:0] ACT_TRAVERSE = 2'd2;
    localparam logic [1:0] ACT_NONE     = 2'd3;

    // status codes of a result beat
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_RANGE = 2'd2;
    localparam logic [1:0] ST_FULL  = 2'd3;

    // command queue between front and back
    localparam int CQ_DEPTH = 2;
    localparam int CQ_AW    = 1;
    localparam int CQ_CW    = 2;

    // result queue at the output
    localparam int OQ_DEPTH = 4;
    localparam int OQ_AW    = 2;
    localparam int OQ_CW    = 3;

    typedef struct packed {
        logic [1:0]         action;
        logic signed [31:0] value;
        logic [7:0]         position;
    } t_cmd;

    typedef struct packed {
        logic [1:0]         status;
        logic signed [31:0] element;
        logic               last;
    } t_result;

endpackage

// ----- sv/olid_front.sv -----
// front end: accepts input beats, drops unused codes, queues commands
module olid_front (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_push,
    output logic                  o_full,
    input  logic [1:0]            i_action,
    input  logic signed [31:0]    i_value,
    input  logic [7:0]            i_position,
    output logic                  o_cmd_vld,
    output olid_pkg::t_cmd        o_cmd,
    input  logic                  i_cmd_pop
);

    olid_pkg::t_cmd                 r_q [olid_pkg::CQ_DEPTH];
    logic [olid_pkg::CQ_AW-1:0]     r_wp;
    logic [olid_pkg::CQ_AW-1:0]     r_rp;
    logic [olid_pkg::CQ_CW-1:0]     r_cnt;
    logic [olid_pkg::CQ_CW-1:0]     n_cnt;
    logic                           acc;
    logic                           wr;
    logic                           rd;

    // accept a beat and classify it; unused code three is swallowed
    assign o_full = (r_cnt == olid_pkg::CQ_CW'(olid_pkg::CQ_DEPTH));
    assign acc    = i_push && !o_full;
    assign wr     = acc && (i_action != olid_pkg::ACT_NONE);
    assign rd     = i_cmd_pop && (r_cnt != '0);

    assign o_cmd_vld = (r_cnt != '0);
    assign o_cmd     = r_q[r_rp];

    // occupancy
    always_comb begin
        n_cnt = r_cnt;
        if (wr && !rd) begin
            n_cnt = r_cnt + olid_pkg::CQ_CW'(1);
        end else if (rd && !wr) begin
            n_cnt = r_cnt - olid_pkg::CQ_CW'(1);
        end
    end

    // pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
            if (wr) begin
                r_wp <= r_wp + olid_pkg::CQ_AW'(1);
            end
            if (rd) begin
                r_rp <= r_rp + olid_pkg::CQ_AW'(1);
            end
        end
    end

    // queue storage
    always_ff @(posedge i_clk) begin
        if (wr) begin
            r_q[r_wp] <= '{action: i_action, value: i_value, position: i_position};
        end
    end

endmodule

// ----- sv/olid_outq.sv -----
// result queue: holds finished result beats until the receiver pops them
module olid_outq (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_wr,
    input  olid_pkg::t_result           i_res,
    input  logic                        i_pop,
    output logic                        o_empty,
    output olid_pkg::t_result           o_res,
    output logic [olid_pkg::OQ_CW-1:0]  o_cnt
);

    olid_pkg::t_result              r_q [olid_pkg::OQ_DEPTH];
    logic [olid_pkg::OQ_AW-1:0]     r_wp;
    logic [olid_pkg::OQ_AW-1:0]     r_rp;
    logic [olid_pkg::OQ_CW-1:0]     r_cnt;
    logic [olid_pkg::OQ_CW-1:0]     n_cnt;
    logic                           rd;

    assign o_empty = (r_cnt == '0);
    assign o_res   = r_q[r_rp];
    assign o_cnt   = r_cnt;
    assign rd      = i_pop && !o_empty;

    // occupancy
    always_comb begin
        n_cnt = r_cnt;
        if (i_wr && !rd) begin
            n_cnt = r_cnt + olid_pkg::OQ_CW'(1);
        end else if (rd && !i_wr) begin
            n_cnt = r_cnt - olid_pkg::OQ_CW'(1);
        end
    end

    // pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
            if (i_wr) begin
                r_wp <= r_wp + olid_pkg::OQ_AW'(1);
            end
            if (rd) begin
                r_rp <= r_rp + olid_pkg::OQ_AW'(1);
            end
        end
    end

    // queue storage
    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            r_q[r_wp] <= i_res;
        end
    end

endmodule

// ----- sv/olid_back.sv -----
// back end: list memory, entry count and the sequencer that runs commands
`include "ordered_list_insert_delete_assert.svh"

module olid_back #(
    parameter int DEPTH = 64
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cmd_vld,
    input  olid_pkg::t_cmd              i_cmd,
    output logic                        o_cmd_pop,
    output logic                        o_res_wr,
    output olid_pkg::t_result           o_res,
    input  logic [olid_pkg::OQ_CW-1:0]  i_oq_cnt
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_TRAV  = 2'd1;
    localparam logic [1:0] S_SHIFT = 2'd2;

    logic signed [31:0] r_mem [DEPTH];
    logic signed [31:0] r_rdata;

    logic [1:0]         r_state;
    logic [1:0]         n_state;
    logic [CW-1:0]      r_count;
    logic [CW-1:0]      n_count;
    logic [CW-1:0]      r_idx;
    logic [CW-1:0]      n_idx;
    logic [CW-1:0]      idx_m1;

    // read stage tags: where the registered read data goes
    logic               r_s2_vld;
    logic               n_s2_vld;
    logic               r_s2_out;
    logic               n_s2_out;
    logic               r_s2_last;
    logic               n_s2_last;
    logic [AW-1:0]      r_s2_waddr;
    logic [AW-1:0]      n_s2_waddr;

    logic               rd_en;
    logic [AW-1:0]      rd_addr;
    logic               mem_we;
    logic [AW-1:0]      mem_waddr;
    logic signed [31:0] mem_wdata;
    logic               space;
    logic               is_full;

    assign idx_m1  = r_idx - CW'(1);
    assign is_full = (r_count == CW'(DEPTH));
    // room in the result queue, counting the beat already in the read stage
    assign space = (({1'b0, i_oq_cnt} + {{olid_pkg::OQ_CW{1'b0}}, r_s2_vld})
                   < (olid_pkg::OQ_CW + 1)'(olid_pkg::OQ_DEPTH));

    // sequencer and read stage
    always_comb begin
        n_state    = r_state;
        n_count    = r_count;
        n_idx      = r_idx;
        n_s2_vld   = 1'b0;
        n_s2_out   = 1'b0;
        n_s2_last  = 1'b0;
        n_s2_waddr = r_s2_waddr;
        o_cmd_pop  = 1'b0;
        o_res_wr   = 1'b0;
        o_res      = '0;
        rd_en      = 1'b0;
        rd_addr    = '0;
        mem_we     = 1'b0;
        mem_waddr  = '0;
        mem_wdata  = '0;

        // read data either leaves as a result or moves one slot down
        if (r_s2_vld) begin
            if (r_s2_out) begin
                o_res_wr      = 1'b1;
                o_res.status  = olid_pkg::ST_OK;
                o_res.element = r_rdata;
                o_res.last    = r_s2_last;
            end else begin
                mem_we    = 1'b1;
                mem_waddr = r_s2_waddr;
                mem_wdata = r_rdata;
            end
        end

        case (r_state)
            S_IDLE: begin
                if (i_cmd_vld && !r_s2_vld && space) begin
                    o_cmd_pop = 1'b1;
                    case (i_cmd.action)
                        olid_pkg::ACT_INSERT: begin
                            o_res_wr   = 1'b1;
                            o_res.last = 1'b1;
                            if (is_full) begin
                                o_res.status = olid_pkg::ST_FULL;
                            end else begin
                                o_res.status = olid_pkg::ST_OK;
                                mem_we       = 1'b1;
                                mem_waddr    = r_count[AW-1:0];
                                mem_wdata    = i_cmd.value;
                                n_count      = r_count + CW'(1);
                            end
                        end
                        olid_pkg::ACT_DELETE: begin
                            if (r_count == '0) begin
                                o_res_wr     = 1'b1;
                                o_res.status = olid_pkg::ST_EMPTY;
                                o_res.last   = 1'b1;
                            end else if (i_cmd.position == 8'd0
                                         || i_cmd.position > 8'(r_count)) begin
                                o_res_wr     = 1'b1;
                                o_res.status = olid_pkg::ST_RANGE;
                                o_res.last   = 1'b1;
                            end else begin
                                rd_en     = 1'b1;
                                rd_addr   = AW'(i_cmd.position - 8'd1);
                                n_s2_vld  = 1'b1;
                                n_s2_out  = 1'b1;
                                n_s2_last = 1'b1;
                                n_count   = r_count - CW'(1);
                                // later entries close the gap
                                if (i_cmd.position < 8'(r_count)) begin
                                    n_state = S_SHIFT;
                                    n_idx   = CW'(i_cmd.position);
                                end
                            end
                        end
                        olid_pkg::ACT_TRAVERSE: begin
                            if (r_count == '0) begin
                                o_res_wr     = 1'b1;
                                o_res.status = olid_pkg::ST_EMPTY;
                                o_res.last   = 1'b1;
                            end else begin
                                rd_en     = 1'b1;
                                rd_addr   = '0;
                                n_s2_vld  = 1'b1;
                                n_s2_out  = 1'b1;
                                n_s2_last = (r_count == CW'(1));
                                if (r_count != CW'(1)) begin
                                    n_state = S_TRAV;
                                    n_idx   = CW'(1);
                                end
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_TRAV: begin
                if (space) begin
                    rd_en     = 1'b1;
                    rd_addr   = r_idx[AW-1:0];
                    n_s2_vld  = 1'b1;
                    n_s2_out  = 1'b1;
                    n_s2_last = (r_idx == r_count - CW'(1));
                    n_idx     = r_idx + CW'(1);
                    if (r_idx == r_count - CW'(1)) begin
                        n_state = S_IDLE;
                    end
                end
            end
            S_SHIFT: begin
                rd_en      = 1'b1;
                rd_addr    = r_idx[AW-1:0];
                n_s2_vld   = 1'b1;
                n_s2_out   = 1'b0;
                n_s2_waddr = idx_m1[AW-1:0];
                n_idx      = r_idx + CW'(1);
                if (r_idx == r_count) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_idx    <= '0;
            r_s2_vld <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_idx    <= n_idx;
            r_s2_vld <= n_s2_vld;
        end
    end

    // read stage tags
    always_ff @(posedge i_clk) begin
        r_s2_out   <= n_s2_out;
        r_s2_last  <= n_s2_last;
        r_s2_waddr <= n_s2_waddr;
    end

    // list memory: one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        if (rd_en) begin
            r_rdata <= r_mem[rd_addr];
        end
    end

    `OLID_ASSERT_ALWAYS(a_count_bound, i_clk, i_rst_n, r_count <= CW'(DEPTH),
        "entry count above depth")
    `OLID_ASSERT_IMPLY(a_shift_idx, i_clk, i_rst_n, r_state == S_SHIFT,
        r_idx <= r_count && r_idx != '0, "shift index outside the list")
    `OLID_ASSERT_IMPLY(a_trav_idx, i_clk, i_rst_n, r_state == S_TRAV,
        r_idx < r_count, "traverse index outside the list")
    `OLID_ASSERT_IMPLY(a_res_room, i_clk, i_rst_n, o_res_wr,
        i_oq_cnt < olid_pkg::OQ_CW'(olid_pkg::OQ_DEPTH), "result queue overrun")

endmodule

// ----- sv/ordered_list_insert_delete.sv -----
// top level of the ordered list: front end, back end and result queue
//
// Ordered list of up to DEPTH signed 32-bit values, head first.
// Input channel: a beat (action, value, position) is taken when i_push is
// high and o_full is low. A small command queue sits behind it, so beats
// keep being taken while the back end works on an earlier command.
// Result channel: while o_empty is low the oldest result beat is on
// o_status, o_element and o_last; i_pop high takes it. o_last marks the
// final result beat of a command.
// Result path: when the back end is free, the result beat of an insert or
// a rejected command passes the command queue and the result queue; the
// first beat of a delete or traverse also passes the registered list
// memory read. A delete then moves every entry behind the deleted position
// down one slot, as the list memory copies one entry per cycle. A traverse
// streams one element per cycle while the result queue has room.
// Unused action code three is taken and gives nothing.
// A stalled receiver fills the four-entry result queue, then the back end
// waits and the command queue raises o_full.
// Reset empties the list and both queues; list memory contents are not
// cleared and no clearing pass runs.
module ordered_list_insert_delete #(
    parameter int DEPTH = 64
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    output logic                o_full,
    input  logic [1:0]          i_action,
    input  logic signed [31:0]  i_value,
    input  logic [7:0]          i_position,
    output logic                o_empty,
    input  logic                i_pop,
    output logic [1:0]          o_status,
    output logic signed [31:0]  o_element,
    output logic                o_last
);

    logic                           cmd_vld;
    olid_pkg::t_cmd                 cmd;
    logic                           cmd_pop;
    logic                           res_wr;
    olid_pkg::t_result              res;
    olid_pkg::t_result              oq_res;
    logic [olid_pkg::OQ_CW-1:0]     oq_cnt;

    // input side
    olid_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (i_push),
        .o_full     (o_full),
        .i_action   (i_action),
        .i_value    (i_value),
        .i_position (i_position),
        .o_cmd_vld  (cmd_vld),
        .o_cmd      (cmd),
        .i_cmd_pop  (cmd_pop)
    );

    // command execution
    olid_back #(
        .DEPTH (DEPTH)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd_vld (cmd_vld),
        .i_cmd     (cmd),
        .o_cmd_pop (cmd_pop),
        .o_res_wr  (res_wr),
        .o_res     (res),
        .i_oq_cnt  (oq_cnt)
    );

    // result side
    olid_outq u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (res_wr),
        .i_res   (res),
        .i_pop   (i_pop),
        .o_empty (o_empty),
        .o_res   (oq_res),
        .o_cnt   (oq_cnt)
    );

    assign o_status  = oq_res.status;
    assign o_element = oq_res.element;
    assign o_last    = oq_res.last;

endmodule
